// ===== src/tmlb_pkg.sv =====
// Shared types and constants for the target-match LED blinker.
package tmlb_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REPORT  = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } cmd_t;

  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_DATA_W = 16;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned MS_W       = 16;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_LEVEL    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ON_TIME_MS      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFF_TIME_MS     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CYCLE_LIMIT     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_POLARITY = 3'd4;

  localparam logic [MS_W-1:0] DEFAULT_TIME_MS = 16'd100;
  localparam logic [MS_W-1:0] COUNT_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [MS_W-1:0]    on_time_ms;
    logic [MS_W-1:0]    off_time_ms;
    logic [MS_W-1:0]    cycle_limit;
    logic               invert_polarity;
  } cfg_t;

  typedef struct packed {
    logic pin_out;
    logic led_lit;
    logic is_blinking;
    logic func_enabled;
  } res_t;

endpackage

// ===== src/tmlb_if.sv =====
// Valid/ready channel interfaces for blinker requests and results.
interface tmlb_in_if import tmlb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [LEVEL_W-1:0] level_value;

  modport source (output valid, cmd, level_value, input ready);
  modport sink (input valid, cmd, level_value, output ready);
endinterface

interface tmlb_out_if;
  logic valid;
  logic ready;
  logic pin_out;
  logic led_lit;
  logic is_blinking;
  logic func_enabled;

  modport source (output valid, pin_out, led_lit, is_blinking, func_enabled, input ready);
  modport sink (input valid, pin_out, led_lit, is_blinking, func_enabled, output ready);
endinterface

// ===== src/tmlb_cfg.sv =====
// Configuration register file for the blinker.
module tmlb_cfg import tmlb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level    <= '0;
      cfg.on_time_ms      <= DEFAULT_TIME_MS;
      cfg.off_time_ms     <= DEFAULT_TIME_MS;
      cfg.cycle_limit     <= '0;
      cfg.invert_polarity <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TARGET_LEVEL:    cfg.target_level    <= wr_data[LEVEL_W-1:0];
        REG_ON_TIME_MS:      cfg.on_time_ms      <= wr_data[MS_W-1:0];
        REG_OFF_TIME_MS:     cfg.off_time_ms     <= wr_data[MS_W-1:0];
        REG_CYCLE_LIMIT:     cfg.cycle_limit     <= wr_data[MS_W-1:0];
        REG_INVERT_POLARITY: cfg.invert_polarity <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tmlb_core.sv =====
// Blink state registers and the single-pass next-state logic for one request.
module tmlb_core import tmlb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [1:0]         cmd,
  input  logic [LEVEL_W-1:0] level_value,
  input  cfg_t               cfg,
  output res_t               res_next
);

  logic            enabled, enabled_next;
  logic            active, active_next;
  logic            lit, lit_next;
  logic            pin, pin_next;
  logic [MS_W-1:0] cycles, cycles_next;
  logic [MS_W-1:0] ms_left, ms_left_next;

  logic            match;
  logic            now_lit;
  logic [MS_W-1:0] cycles_inc;

  assign match      = (level_value == cfg.target_level);
  assign now_lit    = ~lit;
  assign cycles_inc = (cycles < COUNT_MAX) ? cycles + 1'b1 : cycles;

  always_comb begin
    enabled_next = enabled;
    active_next  = active;
    lit_next     = lit;
    pin_next     = pin;
    cycles_next  = cycles;
    ms_left_next = ms_left;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        if (enabled && active) begin
          if (ms_left <= MS_W'(1)) begin
            lit_next = now_lit;
            pin_next = now_lit ^ cfg.invert_polarity;
            ms_left_next = now_lit ? cfg.on_time_ms : cfg.off_time_ms;
            if ((cfg.cycle_limit != '0) && !now_lit) begin
              cycles_next = cycles_inc;
              if (cycles_inc >= cfg.cycle_limit) begin
                // sequence done: go dark, timer keeps its old value
                active_next  = 1'b0;
                lit_next     = 1'b0;
                pin_next     = cfg.invert_polarity;
                ms_left_next = ms_left;
              end
            end
          end else begin
            ms_left_next = ms_left - 1'b1;
          end
        end
      end
      CMD_REPORT, CMD_ENABLE: begin
        // enable re-evaluates the level only on a disabled-to-enabled change
        if ((cmd_t'(cmd) == CMD_REPORT) ? enabled : !enabled) begin
          enabled_next = 1'b1;
          if (match) begin
            if (!active) begin
              active_next  = 1'b1;
              cycles_next  = '0;
              lit_next     = 1'b1;
              pin_next     = ~cfg.invert_polarity;
              ms_left_next = cfg.on_time_ms;
            end
          end else if (active) begin
            active_next = 1'b0;
            lit_next    = 1'b0;
            pin_next    = cfg.invert_polarity;
          end
        end
      end
      default: begin
        if (enabled) begin
          enabled_next = 1'b0;
          active_next  = 1'b0;
          lit_next     = 1'b0;
          pin_next     = cfg.invert_polarity;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
      active  <= 1'b0;
      lit     <= 1'b0;
      pin     <= 1'b0;
      cycles  <= '0;
      ms_left <= '0;
    end else if (adv) begin
      enabled <= enabled_next;
      active  <= active_next;
      lit     <= lit_next;
      pin     <= pin_next;
      cycles  <= cycles_next;
      ms_left <= ms_left_next;
    end
  end

  assign res_next.pin_out      = pin_next;
  assign res_next.led_lit      = lit_next;
  assign res_next.is_blinking  = active_next;
  assign res_next.func_enabled = enabled_next;

  a_active_needs_enable: assert property (@(posedge clk) disable iff (rst)
    active |-> enabled) else $error("blinking while disabled");
  a_dark_when_idle: assert property (@(posedge clk) disable iff (rst)
    !active |-> !lit) else $error("LED lit with no sequence running");
  a_hold_without_adv: assert property (@(posedge clk) disable iff (rst)
    !$past(adv) && !$past(rst) |-> $stable(ms_left) && $stable(cycles) && $stable(lit))
    else $error("state moved with no request advancing");
  a_start_loads_on_time: assert property (@(posedge clk) disable iff (rst)
    adv && !active && active_next |=> lit && cycles == '0)
    else $error("sequence start did not light LED and clear count");

endmodule

// ===== src/target_match_led_blinker.sv =====
// Top level of the target-match LED blinker: request register, core, result register.
//
//   channel  | dir | signals
//   ---------+-----+-------------------------------------------------
//   item     | in  | valid, ready, cmd[1:0], level_value[7:0]
//   result   | out | valid, ready, pin_out, led_lit, is_blinking, func_enabled
//   wr_*     | in  | wr_en, wr_index[2:0], wr_data[15:0]
//
// One request per cycle sustained while results are taken; each result is
// presented after passing the request register and then the result register.
// The state update runs as the request moves from the request register into
// the result register; a stalled result holds both stages.
// rst is synchronous: enabled, not blinking, LED dark, registers at defaults.
module target_match_led_blinker import tmlb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tmlb_in_if.sink               item,
  tmlb_out_if.source            result,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data
);

  cfg_t               cfg;
  res_t               res_next;
  res_t               res;
  logic               req_valid;
  logic [1:0]         req_cmd;
  logic [LEVEL_W-1:0] req_level;
  logic               res_valid;
  logic               adv;

  assign adv        = req_valid && (!res_valid || result.ready);
  assign item.ready = !req_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        req_valid <= item.valid;
      end
      if (adv) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      req_cmd   <= item.cmd;
      req_level <= item.level_value;
    end
    if (adv) begin
      res <= res_next;
    end
  end

  tmlb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tmlb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cmd         (req_cmd),
    .level_value (req_level),
    .cfg         (cfg),
    .res_next    (res_next)
  );

  assign result.valid        = res_valid;
  assign result.pin_out      = res.pin_out;
  assign result.led_lit      = res.led_lit;
  assign result.is_blinking  = res.is_blinking;
  assign result.func_enabled = res.func_enabled;

  a_stalled_req_held: assert property (@(posedge clk) disable iff (rst)
    req_valid && !adv |=> req_valid && $stable(req_cmd) && $stable(req_level))
    else $error("pending request lost or changed under stall");
  a_result_after_adv: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_valid) else $error("advanced request produced no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |-> !adv) else $error("result overwritten while stalled");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the target-match LED blinker: random and directed requests with a predictor.
`timescale 1ns / 100ps

module tb_top;
  import tmlb_pkg::*;

  typedef struct packed {
    cmd_t               cmd;
    logic [LEVEL_W-1:0] level;
  } blink_req_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_index;
  logic [REG_DATA_W-1:0] wr_data;

  tmlb_in_if  item_ch ();
  tmlb_out_if res_ch ();

  target_match_led_blinker dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  blink_req_t pend_req_q[$];
  res_t       led_state_q[$];

  bit calm;
  bit sink_hold;
  bit hold_req;
  bit req_taken;
  int err_count;

  // Predictor copy of the registers and the blinker state
  cfg_t              regs_now;
  logic              enabled;
  logic              blinking;
  logic              led_on;
  logic              pin_lvl;
  logic [MS_W-1:0]   periods_done;
  logic [MS_W-1:0]   ms_left;

  function automatic void set_led(logic lit);
    led_on  = lit;
    pin_lvl = lit ^ regs_now.invert_polarity;
  endfunction

  function automatic void halt_blink();
    blinking = 1'b0;
    set_led(1'b0);
  endfunction

  function automatic void match_level(logic [LEVEL_W-1:0] lvl);
    if (!enabled) return;
    if (lvl == regs_now.target_level) begin
      if (!blinking) begin
        blinking     = 1'b1;
        periods_done = '0;
        set_led(1'b1);
        ms_left      = regs_now.on_time_ms;
      end
    end else if (blinking) begin
      halt_blink();
    end
  endfunction

  function automatic res_t blink_predict(cmd_t op, logic [LEVEL_W-1:0] lvl);
    logic now_lit;
    logic stopped;
    res_t r;
    case (op)
      CMD_TICK: begin
        if (enabled && blinking) begin
          if (ms_left <= 1) begin
            now_lit = !led_on;
            stopped = 1'b0;
            set_led(now_lit);
            // a full period ends on the lit-to-dark toggle
            if (regs_now.cycle_limit != '0 && !now_lit) begin
              if (periods_done != COUNT_MAX) periods_done = periods_done + 1'b1;
              if (periods_done >= regs_now.cycle_limit) begin
                halt_blink();
                stopped = 1'b1;
              end
            end
            if (!stopped) ms_left = now_lit ? regs_now.on_time_ms : regs_now.off_time_ms;
          end else begin
            ms_left = ms_left - 1'b1;
          end
        end
      end
      CMD_REPORT: match_level(lvl);
      CMD_ENABLE: begin
        if (!enabled) begin
          enabled = 1'b1;
          match_level(lvl);
        end
      end
      default: begin
        if (enabled) begin
          enabled = 1'b0;
          halt_blink();
        end
      end
    endcase
    r.pin_out      = pin_lvl;
    r.led_lit      = led_on;
    r.is_blinking  = blinking;
    r.func_enabled = enabled;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering requests
  initial begin
    wait (hold_req);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (80) @(posedge clk);
    sink_hold = 1'b0;
  end

  always @(negedge clk) begin
    blink_req_t nxt;
    if (!rst && (req_taken || !item_ch.valid)) begin
      if (pend_req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
        nxt = pend_req_q.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= nxt.cmd;
        item_ch.level_value <= nxt.level;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  always @(negedge clk)
    res_ch.ready <= !rst && !sink_hold && (calm || $urandom_range(0, 99) >= 21);

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.pin_out, res_ch.led_lit, res_ch.is_blinking, res_ch.func_enabled};
        if (led_state_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result pin=%0b lit=%0b blink=%0b en=%0b",
                     got.pin_out, got.led_lit, got.is_blinking, got.func_enabled);
        end else begin
          want = led_state_q.pop_front();
          if (got.pin_out !== want.pin_out || got.led_lit !== want.led_lit ||
              got.is_blinking !== want.is_blinking ||
              got.func_enabled !== want.func_enabled) begin
            err_count++;
            if (err_count <= 10)
              $display({"mismatch: expected pin=%0b lit=%0b blink=%0b en=%0b, ",
                        "got pin=%0b lit=%0b blink=%0b en=%0b"},
                       want.pin_out, want.led_lit, want.is_blinking, want.func_enabled,
                       got.pin_out, got.led_lit, got.is_blinking, got.func_enabled);
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        req_taken = 1'b1;
        led_state_q.push_back(blink_predict(cmd_t'(item_ch.cmd), item_ch.level_value));
      end
    end
  end

  task automatic push_req(cmd_t op, logic [LEVEL_W-1:0] lvl);
    blink_req_t rq;
    rq.cmd   = op;
    rq.level = lvl;
    pend_req_q.push_back(rq);
  endtask

  task automatic push_random(int unsigned count);
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      push_req(CMD_TICK, 8'($urandom_range(0, 255)));
      else if (pick < 86) push_req(CMD_REPORT, ($urandom_range(0, 99) < 80) ?
                                   regs_now.target_level : 8'($urandom_range(0, 255)));
      else if (pick < 93) push_req(CMD_ENABLE, ($urandom_range(0, 99) < 80) ?
                                   regs_now.target_level : 8'($urandom_range(0, 255)));
      else                push_req(CMD_DISABLE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      REG_TARGET_LEVEL:    regs_now.target_level    = val[LEVEL_W-1:0];
      REG_ON_TIME_MS:      regs_now.on_time_ms      = val;
      REG_OFF_TIME_MS:     regs_now.off_time_ms     = val;
      REG_CYCLE_LIMIT:     regs_now.cycle_limit     = val;
      REG_INVERT_POLARITY: regs_now.invert_polarity = val[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [LEVEL_W-1:0] tl, logic [MS_W-1:0] on_ms,
                           logic [MS_W-1:0] off_ms, logic [MS_W-1:0] lim, logic inv);
    put_reg(REG_TARGET_LEVEL, REG_DATA_W'(tl));
    put_reg(REG_ON_TIME_MS, on_ms);
    put_reg(REG_OFF_TIME_MS, off_ms);
    put_reg(REG_CYCLE_LIMIT, lim);
    put_reg(REG_INVERT_POLARITY, REG_DATA_W'(inv));
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Sampled mid-high phase so driver and monitor updates have settled
  task automatic drain();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      @(posedge clk);
      #0.5;
      busy = pend_req_q.size() != 0 || item_ch.valid || led_state_q.size() != 0;
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [MS_W-1:0] rand_ms();
    return ($urandom_range(0, 7) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 4));
  endfunction

  initial begin
    int unsigned ph;
    rst                 = 1'b1;
    wr_en               = 1'b0;
    wr_index            = '0;
    wr_data             = '0;
    item_ch.valid       = 1'b0;
    item_ch.cmd         = CMD_TICK;
    item_ch.level_value = '0;
    res_ch.ready        = 1'b0;
    calm                = 1'b0;
    sink_hold           = 1'b0;
    hold_req            = 1'b0;
    req_taken           = 1'b0;
    err_count           = 0;
    regs_now.target_level    = '0;
    regs_now.on_time_ms      = DEFAULT_TIME_MS;
    regs_now.off_time_ms     = DEFAULT_TIME_MS;
    regs_now.cycle_limit     = '0;
    regs_now.invert_polarity = 1'b0;
    enabled      = 1'b1;
    blinking     = 1'b0;
    led_on       = 1'b0;
    pin_lvl      = 1'b0;
    periods_done = '0;
    ms_left      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Defaults after reset: idle ticks, disable/enable handling, leaving target
    push_req(CMD_TICK, 8'hFF);
    push_req(CMD_DISABLE, 8'h00);
    push_req(CMD_DISABLE, 8'hFF);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_REPORT, 8'h00);
    push_req(CMD_ENABLE, 8'h00);
    push_req(CMD_ENABLE, 8'h00);
    push_req(CMD_REPORT, 8'h05);
    push_req(CMD_REPORT, 8'h05);
    push_req(CMD_REPORT, 8'h00);
    push_req(CMD_TICK, 8'hAA);
    push_req(CMD_REPORT, 8'h00);
    drain();

    // Zero lit time, count of two, then restart after the sequence finishes
    load_regs(8'hFF, 16'd0, 16'd1, 16'd2, 1'b1);
    push_req(CMD_REPORT, 8'hFF);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_TICK, 8'h00);
    push_req(CMD_REPORT, 8'hFF);
    drain();

    // Polarity change alone leaves the pin until the LED is driven again
    load_regs(8'hFF, 16'd0, 16'd1, 16'd2, 1'b0);
    push_req(CMD_REPORT, 8'hFF);
    push_req(CMD_TICK, 8'h55);
    push_req(CMD_TICK, 8'h55);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      load_regs(8'($urandom_range(0, 255)), rand_ms(), rand_ms(),
                ($urandom_range(0, 3) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 4)),
                1'($urandom_range(0, 1)));
      calm     = (ph == 2) || (ph == 3);
      hold_req = (ph == 3);
      push_random(130);
      drain();
    end
    calm = 1'b0;

    load_regs(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_random(40);
    drain();
    load_regs(8'hFF, 16'd0, 16'd0, 16'd1, 1'b1);
    push_random(20);
    drain();
    repeat (8) @(negedge clk);

    if (err_count == 0 && led_state_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
